>>> rtl/core/tps_pkg.sv
// Shared types and constants for the two-axis PD servo stabilizer.
package tps_pkg;

    localparam int ANGLE_W   = 17;
    localparam int GAIN_W    = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 12;
    localparam int PROD_P_W  = GAIN_W + 1 + ANGLE_W;
    localparam int PROD_D_W  = GAIN_W + 1 + ANGLE_W + 1;
    localparam int ERR_W     = PROD_D_W + 1;

    localparam int PULSE_RESET = 1500;

    localparam logic [CFG_W-1:0] PITCH_P_RESET  = 12'd77;
    localparam logic [CFG_W-1:0] PITCH_D_RESET  = 12'd1408;
    localparam logic [CFG_W-1:0] ROLL_P_RESET   = 12'd154;
    localparam logic [CFG_W-1:0] ROLL_D_RESET   = 12'd1408;
    localparam logic [CFG_W-1:0] DEADBAND_RESET = 12'd128;
    localparam logic [CFG_W-1:0] PMIN_RESET     = 12'd250;
    localparam logic [CFG_W-1:0] PMAX_RESET     = 12'd1900;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PITCH_PROP  = 3'd0,
        CFG_PITCH_DERIV = 3'd1,
        CFG_ROLL_PROP   = 3'd2,
        CFG_ROLL_DERIV  = 3'd3,
        CFG_PITCH_DB    = 3'd4,
        CFG_ROLL_DB     = 3'd5,
        CFG_PULSE_MIN   = 3'd6,
        CFG_PULSE_MAX   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] prop_gain;
        logic [CFG_W-1:0] deriv_gain;
        logic [CFG_W-1:0] deadband;
        logic [CFG_W-1:0] pulse_min;
        logic [CFG_W-1:0] pulse_max;
    } lane_cfg_t;

    typedef struct packed {
        logic load;
        logic advance;
    } lane_ctrl_t;

endpackage

>>> rtl/core/two_axis_pd_servo_stabilizer.sv
// Two-axis PD servo stabilizer top level: config registers, lanes, output merge.
//
// Takes one pitch/roll sample pair per clock while in_stall is low and returns
// one pitch/roll pulse pair per item, in order. An accepted item waits in the
// first stage register and then in the output register, flagged by out_valid:
// one stage forms the deadbanded angle and the PD products, the second applies
// the clamp and pulse step, whose feedback through the pulse register sets the
// rate of one item per cycle while nothing stalls. The output register lets a
// new item enter while a result waits; in_stall rises only when both stages are
// full and out_stall is high. Write configuration only while the block is idle.
module two_axis_pd_servo_stabilizer #(
    parameter int PULSE_BITS      = 12,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int GAIN_FRAC_BITS  = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [tps_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [tps_pkg::CFG_W-1:0]              cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [tps_pkg::ANGLE_W-1:0]     pitch_angle,
    input  logic                                   pitch_valid,
    input  logic signed [tps_pkg::ANGLE_W-1:0]     roll_angle,
    input  logic                                   roll_valid,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [tps_pkg::OUT_W-1:0]              pitch_pulse,
    output logic [tps_pkg::OUT_W-1:0]              roll_pulse
);

    tps_pkg::lane_cfg_t   pitch_cfg_reg, roll_cfg_reg;
    tps_pkg::lane_ctrl_t  ctrl;
    logic                 s1_valid_reg;
    logic                 out_valid_reg;
    logic                 out_ready;
    logic                 s1_adv;
    logic                 in_accept;
    logic [PULSE_BITS-1:0] pitch_new, roll_new;
    logic [tps_pkg::OUT_W-1:0] pitch_out_reg, roll_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_cfg_reg.prop_gain  <= tps_pkg::PITCH_P_RESET;
            pitch_cfg_reg.deriv_gain <= tps_pkg::PITCH_D_RESET;
            pitch_cfg_reg.deadband   <= tps_pkg::DEADBAND_RESET;
            pitch_cfg_reg.pulse_min  <= tps_pkg::PMIN_RESET;
            pitch_cfg_reg.pulse_max  <= tps_pkg::PMAX_RESET;
            roll_cfg_reg.prop_gain   <= tps_pkg::ROLL_P_RESET;
            roll_cfg_reg.deriv_gain  <= tps_pkg::ROLL_D_RESET;
            roll_cfg_reg.deadband    <= tps_pkg::DEADBAND_RESET;
            roll_cfg_reg.pulse_min   <= tps_pkg::PMIN_RESET;
            roll_cfg_reg.pulse_max   <= tps_pkg::PMAX_RESET;
        end
        else if (cfg_write)
        begin
            case (tps_pkg::cfg_idx_t'(cfg_index))
                tps_pkg::CFG_PITCH_PROP:  pitch_cfg_reg.prop_gain  <= cfg_data;
                tps_pkg::CFG_PITCH_DERIV: pitch_cfg_reg.deriv_gain <= cfg_data;
                tps_pkg::CFG_ROLL_PROP:   roll_cfg_reg.prop_gain   <= cfg_data;
                tps_pkg::CFG_ROLL_DERIV:  roll_cfg_reg.deriv_gain  <= cfg_data;
                tps_pkg::CFG_PITCH_DB:    pitch_cfg_reg.deadband   <= cfg_data;
                tps_pkg::CFG_ROLL_DB:     roll_cfg_reg.deadband    <= cfg_data;
                tps_pkg::CFG_PULSE_MIN:
                begin
                    pitch_cfg_reg.pulse_min <= cfg_data;
                    roll_cfg_reg.pulse_min  <= cfg_data;
                end
                tps_pkg::CFG_PULSE_MAX:
                begin
                    pitch_cfg_reg.pulse_max <= cfg_data;
                    roll_cfg_reg.pulse_max  <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_ready    = !out_valid_reg || !out_stall;
    assign s1_adv       = s1_valid_reg && out_ready;
    assign in_stall     = s1_valid_reg && !out_ready;
    assign in_accept    = in_valid && !in_stall;
    assign ctrl.load    = in_accept;
    assign ctrl.advance = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept || s1_adv)
                s1_valid_reg <= in_accept;
            if (out_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    tps_lane #(
        .NEGATE          (1'b0),
        .MAX_INCLUSIVE   (1'b0),
        .PULSE_BITS      (PULSE_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
    ) u_pitch (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (pitch_cfg_reg),
        .ctrl         (ctrl),
        .angle        (pitch_angle),
        .sample_valid (pitch_valid),
        .pulse        (pitch_new)
    );

    tps_lane #(
        .NEGATE          (1'b1),
        .MAX_INCLUSIVE   (1'b1),
        .PULSE_BITS      (PULSE_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
    ) u_roll (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (roll_cfg_reg),
        .ctrl         (ctrl),
        .angle        (roll_angle),
        .sample_valid (roll_valid),
        .pulse        (roll_new)
    );

    // merge both lanes into one output item
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            pitch_out_reg <= tps_pkg::OUT_W'(pitch_new);
            roll_out_reg  <= tps_pkg::OUT_W'(roll_new);
        end
    end

    assign out_valid   = out_valid_reg;
    assign pitch_pulse = pitch_out_reg;
    assign roll_pulse  = roll_out_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced item lost before output");

    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !s1_valid_reg) |=> !out_valid_reg)
        else $error("taken item repeated");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted item dropped");

endmodule

>>> rtl/core/tps_lane.sv
// One axis lane: deadband, PD error products, history and pulse register.
module tps_lane #(
    parameter bit NEGATE          = 1'b0,
    parameter bit MAX_INCLUSIVE   = 1'b0,
    parameter int PULSE_BITS      = 12,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int GAIN_FRAC_BITS  = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tps_pkg::lane_cfg_t                     cfg,
    input  tps_pkg::lane_ctrl_t                    ctrl,
    input  logic signed [tps_pkg::ANGLE_W-1:0]     angle,
    input  logic                                   sample_valid,
    output logic [PULSE_BITS-1:0]                  pulse
);

    localparam int AW      = tps_pkg::ANGLE_W;
    localparam int EW      = tps_pkg::ERR_W;
    localparam int F       = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;
    localparam int SCALE_W = PULSE_BITS + F + 2;
    localparam int SW      = (SCALE_W > EW + 1) ? SCALE_W : EW + 1;

    logic signed [AW-1:0]                 hist_reg, hist_next;
    logic signed [AW:0]                   angle_ext, mag;
    logic signed [AW-1:0]                 x;
    logic signed [AW:0]                   diff;
    logic signed [tps_pkg::PROD_P_W-1:0]  p_prod;
    logic signed [tps_pkg::PROD_D_W-1:0]  d_prod;
    logic signed [EW-1:0]                 err_reg, err_next;
    logic                                 vld_reg;
    logic [PULSE_BITS-1:0]                pulse_reg, pulse_next;
    logic signed [SW-1:0]                 s_val, min_sc, max_sc;
    logic signed [EW:0]                   err_adj, quot;
    logic                                 over_max;
    logic [PULSE_BITS-1:0]                lim_min, lim_max;

    // front: deadband, sign, products
    always_comb
    begin
        angle_ext = {angle[AW-1], angle};
        mag       = angle[AW-1] ? -angle_ext : angle_ext;
        if (mag < $signed({{(AW+1-tps_pkg::CFG_W){1'b0}}, cfg.deadband}))
        begin
            x = '0;
        end
        else if (NEGATE)
        begin
            if (angle == $signed({1'b1, {(AW-1){1'b0}}}))
                x = $signed({1'b0, {(AW-1){1'b1}}});
            else
                x = -angle;
        end
        else
        begin
            x = angle;
        end
        diff     = {x[AW-1], x} - {hist_reg[AW-1], hist_reg};
        p_prod   = $signed({1'b0, cfg.prop_gain}) * x;
        d_prod   = $signed({1'b0, cfg.deriv_gain}) * diff;
        err_next = EW'(p_prod) + EW'(d_prod);
        hist_next = sample_valid ? x : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (ctrl.load)
        begin
            hist_reg <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            err_reg <= err_next;
            vld_reg <= sample_valid;
        end
    end

    // back: hold without a valid sample, else clamp against scaled limits, else step by truncated error
    always_comb
    begin
        lim_min  = PULSE_BITS'(cfg.pulse_min);
        lim_max  = PULSE_BITS'(cfg.pulse_max);
        s_val    = ($signed({{(SW-PULSE_BITS){1'b0}}, pulse_reg}) <<< F)
                   - $signed({{(SW-EW){err_reg[EW-1]}}, err_reg});
        min_sc   = $signed({{(SW-tps_pkg::CFG_W){1'b0}}, cfg.pulse_min}) <<< F;
        max_sc   = $signed({{(SW-tps_pkg::CFG_W){1'b0}}, cfg.pulse_max}) <<< F;
        err_adj  = {err_reg[EW-1], err_reg}
                   + (err_reg[EW-1] ? $signed((EW+1)'((1 << F) - 1)) : '0);
        quot     = err_adj >>> F;
        over_max = MAX_INCLUSIVE ? (s_val >= max_sc) : (s_val > max_sc);
        if (!vld_reg)
            pulse_next = pulse_reg;
        else if (s_val < min_sc)
            pulse_next = lim_min;
        else if (over_max)
            pulse_next = lim_max;
        else
            pulse_next = pulse_reg - quot[PULSE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg <= PULSE_BITS'(tps_pkg::PULSE_RESET);
        end
        else if (ctrl.advance)
        begin
            pulse_reg <= pulse_next;
        end
    end

    assign pulse = pulse_next;

endmodule
